FILE: hw/rtl/lar_pkg.sv
`timescale 1ns / 1ps
package lar_pkg;
    localparam int IN_W        = 32;
    localparam int IN_FRAC     = 16;
    localparam int OUT_FRAC    = 30;
    localparam int OUT_W       = OUT_FRAC + 2;
    localparam int MAG_W       = 62;
    localparam int NA_W        = 30;
    localparam int SUM_W       = 62;
    localparam int ROOT_W      = 31;
    localparam int SQ_REM_W    = 33;
    localparam int SQRT_STEPS  = SUM_W / 2;
    localparam int SHIFT_STEPS = 6;
    localparam int DIV_RW      = 32;
    localparam int NORM_QW     = OUT_FRAC + 1;
    localparam int NUM_W       = IN_W + IN_FRAC;
    localparam int DIV_STEPS   = NUM_W;
    localparam int NORM_LAT    = SHIFT_STEPS + SQRT_STEPS + OUT_FRAC + 5;

    localparam logic [OUT_W-1:0] ONE = OUT_W'(1) << OUT_FRAC;

    typedef logic [2:0][MAG_W-1:0] t_mag3;
    typedef logic [2:0][OUT_W-1:0] t_row;
endpackage

FILE: hw/rtl/lar_shift_cell.sv
`timescale 1ns / 1ps
module lar_shift_cell #(
    parameter int STEP = 1
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [lar_pkg::MAG_W-1:0]  i_or,
    input  lar_pkg::t_mag3             i_mag,
    output logic [lar_pkg::MAG_W-1:0]  o_or,
    output lar_pkg::t_mag3             o_mag
);
    import lar_pkg::*;

    logic [MAG_W-1:0] r_or;
    t_mag3            r_mag;
    logic             lz;

    assign lz = (i_or[MAG_W-1 -: STEP] == '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_or <= lz ? (i_or << STEP) : i_or;
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= lz ? (i_mag[k] << STEP) : i_mag[k];
            end
        end
    end

    assign o_or  = r_or;
    assign o_mag = r_mag;
endmodule

FILE: hw/rtl/lar_sqrt_cell.sv
`timescale 1ns / 1ps
module lar_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [lar_pkg::SUM_W-1:0]     i_rad,
    input  logic [lar_pkg::SQ_REM_W-1:0]  i_rem,
    input  logic [lar_pkg::ROOT_W-1:0]    i_root,
    output logic [lar_pkg::SUM_W-1:0]     o_rad,
    output logic [lar_pkg::SQ_REM_W-1:0]  o_rem,
    output logic [lar_pkg::ROOT_W-1:0]    o_root
);
    import lar_pkg::*;

    logic [SUM_W-1:0]    r_rad;
    logic [SQ_REM_W-1:0] r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [SQ_REM_W+1:0] rem2;
    logic [SQ_REM_W+1:0] trial;
    logic                ge;

    assign rem2  = {i_rem, i_rad[SUM_W-1 -: 2]};
    assign trial = (SQ_REM_W+2)'({i_root, 2'b01});
    assign ge    = (rem2 >= trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= ge ? SQ_REM_W'(rem2 - trial) : SQ_REM_W'(rem2);
            r_root <= {i_root[ROOT_W-2:0], ge};
            r_rad  <= i_rad << 2;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

FILE: hw/rtl/lar_div_cell.sv
`timescale 1ns / 1ps
module lar_div_cell #(
    parameter int RW = 32,
    parameter int QW = 31,
    parameter int NW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [RW-1:0] i_den,
    input  logic [QW-1:0] i_quo,
    input  logic [NW-1:0] i_num,
    output logic [RW-1:0] o_rem,
    output logic [RW-1:0] o_den,
    output logic [QW-1:0] o_quo,
    output logic [NW-1:0] o_num
);
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_den;
    logic [QW-1:0] r_quo;
    logic [NW-1:0] r_num;
    logic [RW-1:0] t;
    logic          ge;

    assign t  = {i_rem[RW-2:0], i_num[NW-1]};
    assign ge = (t >= i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? (t - i_den) : t;
            r_den <= i_den;
            r_quo <= {i_quo[QW-2:0], ge};
            r_num <= i_num << 1;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;
    assign o_num = r_num;
endmodule

FILE: hw/rtl/lar_norm.sv
`timescale 1ns / 1ps
module lar_norm (
    input  logic            i_clk,
    input  logic            i_en,
    input  lar_pkg::t_mag3  i_mag,
    input  logic [2:0]      i_neg,
    output lar_pkg::t_row   o_row
);
    import lar_pkg::*;

    localparam int SB_D = NORM_LAT - 2;
    localparam int AD_D = SQRT_STEPS + 2;

    logic [MAG_W-1:0]          r_or0;
    t_mag3                     r_mag0;
    logic [3:0]                r_sb0;
    logic [3:0]                r_sb [SB_D];
    logic [MAG_W-1:0]          sh_or [SHIFT_STEPS+1];
    t_mag3                     sh_mag [SHIFT_STEPS+1];
    logic [2:0][NA_W-1:0]      na;
    logic [2:0][2*NA_W-1:0]    r_sq;
    logic [SUM_W-1:0]          r_sum;
    logic [2:0][NA_W-1:0]      r_adly [AD_D];
    logic [SUM_W-1:0]          sq_rad [SQRT_STEPS+1];
    logic [SQ_REM_W-1:0]       sq_rem [SQRT_STEPS+1];
    logic [ROOT_W-1:0]         sq_root [SQRT_STEPS+1];
    logic [ROOT_W-1:0]         len;
    logic [DIV_RW-1:0]         dv_rem [3][OUT_FRAC+1];
    logic [DIV_RW-1:0]         dv_den [3][OUT_FRAC+1];
    logic [NORM_QW-1:0]        dv_quo [3][OUT_FRAC+1];
    logic                      dv_num [3][OUT_FRAC+1];

    // front: or of magnitudes steers the shared shift
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_or0  <= i_mag[0] | i_mag[1] | i_mag[2];
            r_mag0 <= i_mag;
            r_sb0  <= {((i_mag[0] | i_mag[1] | i_mag[2]) == '0), i_neg};
            r_sb[0] <= r_sb0;
            for (int k = 1; k < SB_D; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    assign sh_or[0]  = r_or0;
    assign sh_mag[0] = r_mag0;

    for (genvar j = 0; j < SHIFT_STEPS; j++) begin : g_shift
        lar_shift_cell #(.STEP(1 << (SHIFT_STEPS - 1 - j))) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_or  (sh_or[j]),
            .i_mag (sh_mag[j]),
            .o_or  (sh_or[j+1]),
            .o_mag (sh_mag[j+1])
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_na
        assign na[i] = sh_mag[SHIFT_STEPS][i][MAG_W-1 -: NA_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= na[k] * na[k];
            end
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_adly[0] <= na;
            for (int k = 1; k < AD_D; k++) begin
                r_adly[k] <= r_adly[k-1];
            end
        end
    end

    assign sq_rad[0]  = r_sum;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        lar_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rad  (sq_rad[j]),
            .i_rem  (sq_rem[j]),
            .i_root (sq_root[j]),
            .o_rad  (sq_rad[j+1]),
            .o_rem  (sq_rem[j+1]),
            .o_root (sq_root[j+1])
        );
    end

    assign len = sq_root[SQRT_STEPS];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic [ROOT_W-1:0]  a_ext;
        logic               q0;
        logic [DIV_RW-1:0]  r_pr_rem;
        logic [DIV_RW-1:0]  r_pr_den;
        logic [NORM_QW-1:0] r_pr_quo;
        logic [OUT_W-1:0]   r_res;

        assign a_ext = ROOT_W'(r_adly[AD_D-1][i]);
        assign q0    = (a_ext >= len);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pr_rem <= q0 ? DIV_RW'(a_ext - len) : DIV_RW'(a_ext);
                r_pr_den <= DIV_RW'(len);
                r_pr_quo <= NORM_QW'(q0);
            end
        end

        assign dv_rem[i][0] = r_pr_rem;
        assign dv_den[i][0] = r_pr_den;
        assign dv_quo[i][0] = r_pr_quo;
        assign dv_num[i][0] = 1'b0;

        for (genvar j = 0; j < OUT_FRAC; j++) begin : g_div
            lar_div_cell #(.RW(DIV_RW), .QW(NORM_QW), .NW(1)) u_cell (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_rem (dv_rem[i][j]),
                .i_den (dv_den[i][j]),
                .i_quo (dv_quo[i][j]),
                .i_num (dv_num[i][j]),
                .o_rem (dv_rem[i][j+1]),
                .o_den (dv_den[i][j+1]),
                .o_quo (dv_quo[i][j+1]),
                .o_num (dv_num[i][j+1])
            );
        end

        logic               rnd;
        logic [NORM_QW-1:0] qr;

        assign rnd = ({dv_rem[i][OUT_FRAC], 1'b0} >= {1'b0, dv_den[i][OUT_FRAC]});
        assign qr  = dv_quo[i][OUT_FRAC] + NORM_QW'(rnd);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_sb[SB_D-1][3]) begin
                    r_res <= '0;
                end else if (r_sb[SB_D-1][i]) begin
                    r_res <= OUT_W'(0) - OUT_W'(qr);
                end else begin
                    r_res <= OUT_W'(qr);
                end
            end
        end

        assign o_row[i] = r_res;
    end
endmodule

FILE: hw/rtl/look_at_rotation_matrix.sv
`timescale 1ns / 1ps
// channel  direction  handshake            word
// target   in         i_valid / o_ready    i_target_x, i_target_y, i_target_z
// matrix   out        o_valid / i_ready    o_m00 .. o_m22, o_degenerate
//
// one word accepted per cycle while o_ready is high
// the path runs through the 48-step ratio divider and three normalize chains of 72 stages
// (shift, square root, per-lane divide); the cross product sits between them
// reset (synchronous, active low) clears the valid chain and the output stage
// a stalled output parks one word in a skid register; o_ready drops while it is full
module look_at_rotation_matrix (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [lar_pkg::IN_W-1:0]    i_target_x,
    input  logic signed [lar_pkg::IN_W-1:0]    i_target_y,
    input  logic signed [lar_pkg::IN_W-1:0]    i_target_z,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [lar_pkg::OUT_W-1:0]   o_m00,
    output logic signed [lar_pkg::OUT_W-1:0]   o_m01,
    output logic signed [lar_pkg::OUT_W-1:0]   o_m02,
    output logic signed [lar_pkg::OUT_W-1:0]   o_m10,
    output logic signed [lar_pkg::OUT_W-1:0]   o_m11,
    output logic signed [lar_pkg::OUT_W-1:0]   o_m12,
    output logic signed [lar_pkg::OUT_W-1:0]   o_m20,
    output logic signed [lar_pkg::OUT_W-1:0]   o_m21,
    output logic signed [lar_pkg::OUT_W-1:0]   o_m22,
    output logic                               o_degenerate
);
    import lar_pkg::*;

    localparam int L_Y  = DIV_STEPS + 3 + 2 * NORM_LAT;
    localparam int ZD   = DIV_STEPS + NORM_LAT + 3;
    localparam int XD   = NORM_LAT + 2;
    localparam int CP_W = 2 * OUT_W;

    typedef struct packed {
        t_row x;
        t_row y;
        t_row z;
        logic deg;
    } t_res;

    logic              en;
    logic [L_Y:0]      r_vld;
    logic [L_Y:0]      r_deg;
    logic [IN_W-1:0]   r_tx;
    logic [IN_W-1:0]   r_ty;
    logic [IN_W-1:0]   r_tz;
    logic [IN_W-1:0]   mag_x;
    logic [IN_W-1:0]   mag_y;
    logic [IN_W-1:0]   mag_z;
    logic              rneg0;
    logic [DIV_STEPS-1:0] r_rneg_d;

    logic [DIV_RW-1:0] rd_rem [DIV_STEPS+1];
    logic [DIV_RW-1:0] rd_den [DIV_STEPS+1];
    logic [NUM_W-1:0]  rd_quo [DIV_STEPS+1];
    logic [NUM_W-1:0]  rd_num [DIV_STEPS+1];
    logic [NUM_W-1:0]  lim;
    logic [IN_W-1:0]   r_ratio;
    logic              r_ratio_neg;

    t_row              rz;
    t_row              rx;
    t_row              ry;
    t_row              r_zdly [ZD];
    t_row              r_xdly [XD];
    t_row              rz_c;
    logic signed [CP_W-1:0] r_p [6];
    logic signed [CP_W-1:0] r_cv [3];
    logic [CP_W-1:0]   cv_abs [3];
    t_mag3             cv_mag;
    logic [2:0]        cv_neg;

    t_res              res;
    t_res              r_out;
    t_res              r_skid;
    logic              r_out_vld;
    logic              r_skid_vld;
    logic              take;
    logic              arrive;

    assign en      = !r_skid_vld;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L_Y-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx     <= i_target_x;
            r_ty     <= i_target_y;
            r_tz     <= i_target_z;
            r_deg    <= {r_deg[L_Y-1:0], (i_target_z == '0)};
            r_rneg_d <= {r_rneg_d[DIV_STEPS-2:0], rneg0};
        end
    end

    assign mag_x = r_tx[IN_W-1] ? (IN_W'(0) - r_tx) : r_tx;
    assign mag_y = r_ty[IN_W-1] ? (IN_W'(0) - r_ty) : r_ty;
    assign mag_z = r_tz[IN_W-1] ? (IN_W'(0) - r_tz) : r_tz;
    assign rneg0 = (r_tx[IN_W-1] == r_tz[IN_W-1]);

    // ratio |tx| * 2^16 / |tz|, one quotient bit per cell
    assign rd_rem[0] = '0;
    assign rd_den[0] = DIV_RW'(mag_z);
    assign rd_quo[0] = '0;
    assign rd_num[0] = {mag_x, IN_FRAC'(0)};

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_ratio
        lar_div_cell #(.RW(DIV_RW), .QW(NUM_W), .NW(NUM_W)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (rd_rem[j]),
            .i_den (rd_den[j]),
            .i_quo (rd_quo[j]),
            .i_num (rd_num[j]),
            .o_rem (rd_rem[j+1]),
            .o_den (rd_den[j+1]),
            .o_quo (rd_quo[j+1]),
            .o_num (rd_num[j+1])
        );
    end

    assign lim = r_rneg_d[DIV_STEPS-1] ? (NUM_W'(1) << (IN_W - 1))
                                       : ((NUM_W'(1) << (IN_W - 1)) - NUM_W'(1));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ratio     <= (rd_quo[DIV_STEPS] > lim) ? IN_W'(lim)
                                                     : IN_W'(rd_quo[DIV_STEPS]);
            r_ratio_neg <= r_rneg_d[DIV_STEPS-1];
        end
    end

    lar_norm u_norm_z (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag ({MAG_W'(mag_z), MAG_W'(mag_y), MAG_W'(mag_x)}),
        .i_neg ({r_tz[IN_W-1], r_ty[IN_W-1], r_tx[IN_W-1]}),
        .o_row (rz)
    );

    lar_norm u_norm_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag ({MAG_W'(r_ratio), MAG_W'(0), MAG_W'(1) << IN_FRAC}),
        .i_neg ({r_ratio_neg, 2'b00}),
        .o_row (rx)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zdly[0] <= rz;
            for (int k = 1; k < ZD; k++) begin
                r_zdly[k] <= r_zdly[k-1];
            end
            r_xdly[0] <= rx;
            for (int k = 1; k < XD; k++) begin
                r_xdly[k] <= r_xdly[k-1];
            end
        end
    end

    assign rz_c = r_zdly[DIV_STEPS];

    // cross product row z x row x
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= $signed(rz_c[1]) * $signed(rx[2]);
            r_p[1] <= $signed(rz_c[2]) * $signed(rx[1]);
            r_p[2] <= $signed(rz_c[2]) * $signed(rx[0]);
            r_p[3] <= $signed(rz_c[0]) * $signed(rx[2]);
            r_p[4] <= $signed(rz_c[0]) * $signed(rx[1]);
            r_p[5] <= $signed(rz_c[1]) * $signed(rx[0]);
            r_cv[0] <= r_p[0] - r_p[1];
            r_cv[1] <= r_p[2] - r_p[3];
            r_cv[2] <= r_p[4] - r_p[5];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_cv
        assign cv_neg[i] = r_cv[i][CP_W-1];
        assign cv_abs[i] = cv_neg[i] ? (CP_W'(0) - r_cv[i]) : r_cv[i];
        assign cv_mag[i] = cv_abs[i][MAG_W-1:0];
    end

    lar_norm u_norm_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (cv_mag),
        .i_neg (cv_neg),
        .o_row (ry)
    );

    always_comb begin
        res.deg = r_deg[L_Y];
        if (r_deg[L_Y]) begin
            res.x = {OUT_W'(0), OUT_W'(0), ONE};
            res.y = {OUT_W'(0), ONE, OUT_W'(0)};
            res.z = {ONE, OUT_W'(0), OUT_W'(0)};
        end else begin
            res.x = r_xdly[XD-1];
            res.y = ry;
            res.z = r_zdly[ZD-1];
        end
    end

    // output word plus skid
    assign take   = r_out_vld && i_ready;
    assign arrive = en && r_vld[L_Y];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (r_skid_vld) begin
                if (take) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (arrive) begin
                if (r_out_vld && !i_ready) begin
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out_vld <= 1'b1;
                end
            end else if (take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (arrive) begin
            if (r_out_vld && !i_ready) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_m00        = r_out.x[0];
    assign o_m01        = r_out.x[1];
    assign o_m02        = r_out.x[2];
    assign o_m10        = r_out.y[0];
    assign o_m11        = r_out.y[1];
    assign o_m12        = r_out.y[2];
    assign o_m20        = r_out.z[0];
    assign o_m21        = r_out.z[1];
    assign o_m22        = r_out.z[2];
    assign o_degenerate = r_out.deg;

`ifndef SYNTH
    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word without output word");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !i_ready |=> r_skid_vld)
        else $error("skid word lost while stalled");

    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_m00 == ONE && o_m11 == ONE && o_m22 == ONE
            && o_m01 == '0 && o_m02 == '0 && o_m10 == '0
            && o_m12 == '0 && o_m20 == '0 && o_m21 == '0)
        else $error("degenerate word is not identity");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_m20 <= $signed(ONE) && o_m20 >= -$signed(ONE)
            && o_m02 <= $signed(ONE) && o_m02 >= -$signed(ONE))
        else $error("matrix element beyond unit range");
`endif
endmodule

FILE: verif/lar_checker.sv
`timescale 1ns / 1ps
module lar_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_ready_in,
    input  logic signed [lar_pkg::IN_W-1:0]  i_tx,
    input  logic signed [lar_pkg::IN_W-1:0]  i_ty,
    input  logic signed [lar_pkg::IN_W-1:0]  i_tz,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [8:0][lar_pkg::OUT_W-1:0]   i_mat,
    input  logic                             i_degen,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_matrix_count
);
    import lar_pkg::*;

    typedef struct {
        logic [8:0][OUT_W-1:0] m;
        logic                  degen;
    } t_matrix;

    t_matrix expected_matrices[$];

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > s) bits >>= 2;
        while (bits != 0) begin
            if (s >= res + bits) begin
                s -= res + bits;
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    function automatic void unit_vector(input longint v[3], output longint o[3]);
        longint unsigned a[3], m, s, len, q, r;
        bit neg[3];
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            a[i] = neg[i] ? -v[i] : v[i];
            if (a[i] > m) m = a[i];
        end
        if (m == 0) begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return;
        end
        while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) a[i] >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) s += a[i] * a[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (a[i] >= len) ? 1 : 0;
            r = a[i] - q * len;
            for (int k = 0; k < OUT_FRAC; k++) begin
                r <<= 1;
                q <<= 1;
                if (r >= len) begin
                    r -= len;
                    q |= 1;
                end
            end
            if (2 * r >= len) q++;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic t_matrix look_at(logic signed [IN_W-1:0] tx, logic signed [IN_W-1:0] ty,
                                        logic signed [IN_W-1:0] tz);
        t_matrix res;
        longint t[3], xv[3], cv[3], rx[3], ry[3], rz[3];
        longint unsigned num, den, q, lim;
        bit rneg;
        if (tz == 0) begin
            res.m = '0;
            res.m[0] = ONE;
            res.m[4] = ONE;
            res.m[8] = ONE;
            res.degen = 1'b1;
            return res;
        end
        t[0] = tx; t[1] = ty; t[2] = tz;
        unit_vector(t, rz);
        num = (tx < 0 ? -t[0] : t[0]) << IN_FRAC;
        den = tz < 0 ? -t[2] : t[2];
        q = num / den;
        rneg = (tx < 0) == (tz < 0);
        lim = 64'd1 << (IN_W - 1);
        if (!rneg) lim -= 1;
        if (q > lim) q = lim;
        xv[0] = 64'd1 << IN_FRAC;
        xv[1] = 0;
        xv[2] = rneg ? -longint'(q) : longint'(q);
        unit_vector(xv, rx);
        cv[0] = rz[1] * rx[2] - rz[2] * rx[1];
        cv[1] = rz[2] * rx[0] - rz[0] * rx[2];
        cv[2] = rz[0] * rx[1] - rz[1] * rx[0];
        unit_vector(cv, ry);
        for (int i = 0; i < 3; i++) begin
            res.m[i] = rx[i][OUT_W-1:0];
            res.m[3+i] = ry[i][OUT_W-1:0];
            res.m[6+i] = rz[i][OUT_W-1:0];
        end
        res.degen = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("mismatch %0d: %s got %h want %h", o_matrix_count, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_matrix_count = 0;
    end

    assign o_pending = expected_matrices.size();

    always @(posedge i_clk) begin
        t_matrix w;
        if (i_rst_n && i_valid && i_ready_in)
            expected_matrices.push_back(look_at(i_tx, i_ty, i_tz));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_matrices.size() == 0) begin
                report_mismatch("unexpected word", OUT_W'(0), OUT_W'(0));
            end else begin
                w = expected_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                    if (i_mat[i] !== w.m[i])
                        report_mismatch($sformatf("m%0d%0d", i / 3, i % 3), i_mat[i], w.m[i]);
                if (i_degen !== w.degen)
                    report_mismatch("degenerate", OUT_W'(i_degen), OUT_W'(w.degen));
            end
            o_matrix_count++;
        end
    end
endmodule

FILE: verif/tb_look_at_rotation_matrix.sv
`timescale 1ns / 1ps
module tb_look_at_rotation_matrix;
    import lar_pkg::*;

    localparam int N_RANDOM = 730;
    localparam int WATCHDOG = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [IN_W-1:0] tx = '0, ty = '0, tz = '0;
    logic o_ready, o_valid, o_degenerate;
    logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    int fail_count, pending, matrix_count, sent_count, idle_cycles;
    bit calm, hold_off;

    always #5 i_clk = ~i_clk;

    look_at_rotation_matrix dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_target_x(tx), .i_target_y(ty), .i_target_z(tz),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_m00(m00), .o_m01(m01), .o_m02(m02), .o_m10(m10), .o_m11(m11),
        .o_m12(m12), .o_m20(m20), .o_m21(m21), .o_m22(m22),
        .o_degenerate(o_degenerate)
    );

    lar_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_tx(tx), .i_ty(ty), .i_tz(tz), .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_mat({m22, m21, m20, m12, m11, m10, m02, m01, m00}), .i_degen(o_degenerate),
        .o_fail_count(fail_count), .o_pending(pending), .o_matrix_count(matrix_count)
    );

    function automatic logic [IN_W-1:0] rand_component();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed(IN_W'($urandom_range(0, 255))) - 128;
            2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            3: return ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000) ^ 4'($urandom);
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    task automatic send_word(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic [IN_W-1:0] z);
        while (!calm && $urandom_range(0, 99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        tx <= x;
        ty <= y;
        tz <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_count++;
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else i_ready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired, %0d words pending", pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // long output stall while input keeps coming
    initial begin
        hold_off = 1'b0;
        wait (sent_count == 40);
        hold_off = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        logic [IN_W-1:0] d [0:19][0:2];
        sent_count = 0;
        idle_cycles = 0;
        calm = 1'b0;
        d = '{'{32'h0001_0000, 0, 32'h0001_0000}, '{0, 0, 32'h0001_0000},
              '{32'h1234_0000, 32'h0000_5000, 0}, '{0, 0, 0},
              '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
              '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
              '{32'h7fff_ffff, 0, 1}, '{32'h8000_0000, 0, 1},
              '{32'h7fff_ffff, 0, 32'hffff_ffff}, '{32'h8000_0000, 0, 32'hffff_ffff},
              '{0, 32'h7fff_ffff, 1}, '{0, 32'h8000_0000, 32'h8000_0000},
              '{1, 1, 1}, '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
              '{0, 0, 32'h8000_0000}, '{0, 0, 32'h7fff_ffff},
              '{32'hffff_0000, 32'h0002_0000, 32'hfffd_0000},
              '{32'h0000_8000, 32'h8000_0000, 0}, '{0, 32'h0001_0000, 32'h0000_0001},
              '{32'h4000_0000, 32'hc000_0000, 32'h0000_0100}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < 20; i++) send_word(d[i][0], d[i][1], d[i][2]);
        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i >= 300 && i < 420);
            send_word(rand_component(), rand_component(),
                      $urandom_range(0, 15) == 0 ? '0 : rand_component());
        end
        i_valid <= 1'b0;
        calm = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        $display("sent %0d target vectors incl. degenerate and saturating ratios", sent_count);
        $display("checked %0d matrices under random stalls and one long output hold", matrix_count);
        if (fail_count == 0 && pending == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
